### src/tt_pkg.sv
// ----------------------------------------------------------------------------
// tt_pkg: shared constants and types of the timeout table
// Table geometry, field widths, operation and status codes, and the structs
// that travel between the sequencer, the entry store and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tt_pkg;

  localparam int ENTRIES  = 32;
  localparam int KEY_BITS = 16;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam int OPCODE_W = 2;
  localparam int KEY_W    = 16;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  localparam logic KIND_EXPIRY  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [TIME_W-1:0] DEADLINE_MAX = '1;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [KEY_W-1:0]    key;
    logic [TIME_W-1:0]   timeout;
    logic [TIME_W-1:0]   now;
  } item_t;

  typedef struct packed {
    logic                kind;
    logic [KEY_W-1:0]    key_res;
    logic [STATUS_W-1:0] status;
    logic                has_next;
    logic [TIME_W-1:0]   next_delay;
    logic                last;
  } result_t;

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    idx;
    logic [KEY_BITS-1:0] key;
    logic [TIME_W-1:0]   deadline;
  } store_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } store_clr_t;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [TIME_W-1:0]   deadline;
  } store_rd_t;

endpackage

`default_nettype wire

### src/tt_intf.sv
// ----------------------------------------------------------------------------
// tt_intf: valid/ready channels of the timeout table
// One interface for the operation channel and one for the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface tt_in_if;
  import tt_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [KEY_W-1:0]    key;
  logic [TIME_W-1:0]   timeout;
  logic [TIME_W-1:0]   now;

  modport source (output valid, output opcode, output key, output timeout, output now,
                  input ready);
  modport sink   (input valid, input opcode, input key, input timeout, input now,
                  output ready);
endinterface

interface tt_out_if;
  import tt_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [KEY_W-1:0]    key_res;
  logic [STATUS_W-1:0] status;
  logic                has_next;
  logic [TIME_W-1:0]   next_delay;
  logic                last;

  modport source (output valid, output kind, output key_res, output status,
                  output has_next, output next_delay, output last, input ready);
  modport sink   (input valid, input kind, input key_res, input status,
                  input has_next, input next_delay, input last, output ready);
endinterface

`default_nettype wire

### src/timeout_table_unit.sv
// ----------------------------------------------------------------------------
// timeout_table_unit: table of per-key timeouts
// Each operation beat (add, remove or tick) scans the whole table once, one
// entry per cycle while the result channel does not stall, through a single
// compare unit on a memory with one read port, then commits the update and
// issues the summary beat. The input is ready only while no item is in work.
// A tick first emits one expiry beat per removed key in ascending entry
// order; every item ends with a summary beat carrying the status and the
// delay to the earliest remaining deadline. Results pass through an output
// register, so a finished beat may wait for the sink while the scan moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module timeout_table_unit (
  input  wire   clk_i,
  input  wire   rst_ni,
  tt_in_if.sink    in_i,
  tt_out_if.source out_o
);
  import tt_pkg::*;

  item_t      item;
  store_rd_t  rd;
  store_wr_t  wr;
  store_clr_t clr;
  result_t    res;
  logic       rd_en;
  logic [IDX_W-1:0] rd_idx;
  logic       res_valid;
  logic       res_ready;
  logic       out_valid_q;
  result_t    out_q;

  assign item.opcode  = in_i.opcode;
  assign item.key     = in_i.key;
  assign item.timeout = in_i.timeout;
  assign item.now     = in_i.now;

  tt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .item_i      (item),
    .rd_en_o     (rd_en),
    .rd_idx_o    (rd_idx),
    .rd_i        (rd),
    .wr_o        (wr),
    .clr_o       (clr),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  tt_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_idx_i (rd_idx),
    .rd_o     (rd),
    .wr_i     (wr),
    .clr_i    (clr)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_q.kind;
  assign out_o.key_res    = out_q.key_res;
  assign out_o.status     = out_q.status;
  assign out_o.has_next   = out_q.has_next;
  assign out_o.next_delay = out_q.next_delay;
  assign out_o.last       = out_q.last;

endmodule

`default_nettype wire

### src/tt_store.sv
// ----------------------------------------------------------------------------
// tt_store: entry store of the timeout table
// Key and deadline memory with one write port and one registered read port,
// plus a flip-flop valid bit per entry that reset clears.
// ----------------------------------------------------------------------------
`default_nettype none

module tt_store (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     rd_en_i,
  input  wire [tt_pkg::IDX_W-1:0] rd_idx_i,
  output tt_pkg::store_rd_t       rd_o,
  input  tt_pkg::store_wr_t       wr_i,
  input  tt_pkg::store_clr_t      clr_i
);
  import tt_pkg::*;

  logic [KEY_BITS-1:0] key_mem [ENTRIES];
  logic [TIME_W-1:0]   dl_mem  [ENTRIES];
  logic [ENTRIES-1:0]  valid_q;
  logic                rd_valid_q;
  logic [KEY_BITS-1:0] rd_key_q;
  logic [TIME_W-1:0]   rd_dl_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      key_mem[wr_i.idx] <= wr_i.key;
      dl_mem[wr_i.idx]  <= wr_i.deadline;
    end
    if (rd_en_i) begin
      rd_key_q <= key_mem[rd_idx_i];
      rd_dl_q  <= dl_mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.idx] <= 1'b1;
      end
      if (clr_i.en) begin
        valid_q[clr_i.idx] <= 1'b0;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_idx_i];
      end
    end
  end

  assign rd_o.valid    = rd_valid_q;
  assign rd_o.key      = rd_key_q;
  assign rd_o.deadline = rd_dl_q;

endmodule

`default_nettype wire

### src/tt_seq.sv
// ----------------------------------------------------------------------------
// tt_seq: scan sequencer of the timeout table
// Walks the store one entry per cycle unless stalled, through a shared compare
// unit that finds the key, the lowest free slot, expired entries and earliest
// remaining deadline, then commits the update and issues the summary beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tt_seq (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  tt_pkg::item_t           item_i,
  output logic                    rd_en_o,
  output logic [tt_pkg::IDX_W-1:0] rd_idx_o,
  input  tt_pkg::store_rd_t       rd_i,
  output tt_pkg::store_wr_t       wr_o,
  output tt_pkg::store_clr_t      clr_o,
  output logic                    res_valid_o,
  input  wire                     res_ready_i,
  output tt_pkg::result_t         res_o
);
  import tt_pkg::*;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_FINISH  = 2'd2;
  localparam logic [1:0] S_SUMMARY = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [OPCODE_W-1:0] op_q, op_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic [TIME_W-1:0]   dl_q, dl_d;
  logic [CNT_W-1:0]    ptr_q, ptr_d;
  logic                ev_vld_q, ev_vld_d;
  logic [IDX_W-1:0]    ev_idx_q, ev_idx_d;
  logic                hit_q, hit_d;
  logic [IDX_W-1:0]    hit_idx_q, hit_idx_d;
  logic                free_q, free_d;
  logic [IDX_W-1:0]    free_idx_q, free_idx_d;
  logic                min_vld_q, min_vld_d;
  logic [TIME_W-1:0]   min_q, min_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic [TIME_W:0] sum;
  logic            match, expired, emit, stall, drop, cand, lower;

  assign sum = {1'b0, item_i.now} + {1'b0, item_i.timeout};

  // Compare unit shared by every entry of the scan.
  assign match   = rd_i.valid && (rd_i.key == key_q);
  assign expired = rd_i.valid && (rd_i.deadline < now_q);
  assign emit    = ev_vld_q && (op_q == OP_TICK) && expired;
  assign stall   = emit && !res_ready_i;
  // The entry an add overwrites or a remove deletes leaves the minimum search.
  assign drop    = match && ((op_q == OP_ADD) || (op_q == OP_REMOVE));
  assign cand    = rd_i.valid && !expired && !drop;
  assign lower   = !min_vld_q || (rd_i.deadline < min_q);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    now_d      = now_q;
    dl_d       = dl_q;
    ptr_d      = ptr_q;
    ev_vld_d   = ev_vld_q;
    ev_idx_d   = ev_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    min_vld_d  = min_vld_q;
    min_d      = min_q;
    status_d   = status_q;

    in_ready_o  = 1'b0;
    rd_en_o     = 1'b0;
    rd_idx_o    = ptr_q[IDX_W-1:0];
    wr_o        = '0;
    clr_o       = '0;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d      = item_i.opcode;
          key_d     = KEY_BITS'(item_i.key);
          now_d     = item_i.now;
          dl_d      = sum[TIME_W] ? DEADLINE_MAX : sum[TIME_W-1:0];
          ptr_d     = '0;
          ev_vld_d  = 1'b0;
          hit_d     = 1'b0;
          free_d    = 1'b0;
          min_vld_d = 1'b0;
          status_d  = ST_OK;
          state_d   = S_SCAN;
        end
      end

      S_SCAN: begin
        if (!stall) begin
          if (ptr_q < CNT_W'(ENTRIES)) begin
            rd_en_o  = 1'b1;
            ev_vld_d = 1'b1;
            ev_idx_d = ptr_q[IDX_W-1:0];
            ptr_d    = ptr_q + CNT_W'(1);
          end else begin
            ev_vld_d = 1'b0;
          end
          if (ev_vld_q) begin
            if (match && !hit_q) begin
              hit_d     = 1'b1;
              hit_idx_d = ev_idx_q;
            end
            if (!rd_i.valid && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = ev_idx_q;
            end
            if (cand && lower) begin
              min_vld_d = 1'b1;
              min_d     = rd_i.deadline;
            end
            if (emit) begin
              res_valid_o   = 1'b1;
              res_o.kind    = KIND_EXPIRY;
              res_o.key_res = KEY_W'(rd_i.key);
              clr_o.en      = 1'b1;
              clr_o.idx     = ev_idx_q;
            end
          end
        end
        if ((ptr_q == CNT_W'(ENTRIES)) && !ev_vld_q) begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        case (op_q)
          OP_ADD: begin
            if (hit_q || free_q) begin
              wr_o.en       = 1'b1;
              wr_o.idx      = hit_q ? hit_idx_q : free_idx_q;
              wr_o.key      = key_q;
              wr_o.deadline = dl_q;
              if (!min_vld_q || (dl_q < min_q)) begin
                min_vld_d = 1'b1;
                min_d     = dl_q;
              end
            end else begin
              status_d = ST_FULL;
            end
          end
          OP_REMOVE: begin
            if (hit_q) begin
              clr_o.en  = 1'b1;
              clr_o.idx = hit_idx_q;
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          default: begin
          end
        endcase
        state_d = S_SUMMARY;
      end

      S_SUMMARY: begin
        res_valid_o  = 1'b1;
        res_o.kind   = KIND_SUMMARY;
        res_o.status = status_q;
        res_o.last   = 1'b1;
        // A deadline equal to now gives a zero delay, which reports as none.
        if (min_vld_q && (min_q != now_q)) begin
          res_o.has_next   = 1'b1;
          res_o.next_delay = min_q - now_q;
        end
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ptr_q     <= '0;
      ev_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      min_vld_q <= 1'b0;
      status_q  <= ST_OK;
      op_q      <= OP_ADD;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      ev_vld_q  <= ev_vld_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      min_vld_q <= min_vld_d;
      status_q  <= status_d;
      op_q      <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    now_q      <= now_d;
    dl_q       <= dl_d;
    ev_idx_q   <= ev_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    min_q      <= min_d;
  end

  a_wr_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_o.en && clr_o.en))
    else $error("store write and clear in the same cycle");

  a_eval_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_vld_q |-> (state_q == S_SCAN))
    else $error("entry evaluation outside the scan");

  a_last_is_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.last == res_o.kind))
    else $error("last flag does not match the beat kind");

  a_summary_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i && res_o.last) |=> (state_q == S_IDLE))
    else $error("sequencer not idle after the summary beat");

  a_expiry_only_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.kind == KIND_EXPIRY)) |-> (op_q == OP_TICK))
    else $error("expiry beat outside a tick");

endmodule

`default_nettype wire
